>>> hw/rtl/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

  localparam int WIN_LEN = 3;
  localparam int SLOT_W  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int DIST_W  = 10;
  localparam int SPEED_W = 12;
  localparam int MOT_W   = 3;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [DIST_W-1:0]  WINDOW_RESET   = DIST_W'(100);
  localparam logic [DIST_W-1:0]  STOP_DIST_RST  = DIST_W'(7);
  localparam logic [SPEED_W-1:0] DRIVE_SPD_RST  = SPEED_W'(1000);
  localparam logic [SLOT_W-1:0]  SLOT_TOP       = SLOT_W'(WIN_LEN - 1);

  localparam logic [MOT_W-1:0] MOT_STOP  = 3'd0;
  localparam logic [MOT_W-1:0] MOT_FWD   = 3'd1;
  localparam logic [MOT_W-1:0] MOT_BACK  = 3'd2;
  localparam logic [MOT_W-1:0] MOT_LEFT  = 3'd3;
  localparam logic [MOT_W-1:0] MOT_RIGHT = 3'd4;
  localparam logic [MOT_W-1:0] MOT_NONE  = 3'd5;

  localparam logic REG_STOP_DIST = 1'b0;
  localparam logic REG_DRIVE_SPD = 1'b1;

  typedef struct packed {
    logic l;
    logic r;
    logic fl;
    logic fm;
    logic fr;
  } ir_flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/ir_docking_steer_controller_core.sv
// Docking steer controller: one motion command per control tick.
// Input channel (in_valid/in_ready) carries a rear range sample and five
// infrared beacon flags; result channel (out_valid/out_ready) carries the
// motion code, its speed and the docked flag. Each input beat yields
// exactly one result beat.
// A beat is captured in an input register, evaluated by the window and
// steering logic, and lands in the result register, which raises
// out_valid; a receiver stall can hold the beat in the input register.
// The block takes one beat per cycle while out_ready stays high.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only when both are occupied, and the
// block resumes at full rate as soon as out_ready returns.
// The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// stop_distance at 0x0 and drive_speed at 0x4; pready is always high.
// Write registers only while no beat is in flight.
// Synchronous reset (rst_n low) empties both registers, restores the
// range windows to 100, rearms both turns and restores stop_distance 7
// and drive_speed 1000.
`default_nettype none
module ir_docking_steer_controller_core import dsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [DIST_W-1:0]  in_distance,
  input  wire logic               in_ir_left,
  input  wire logic               in_ir_right,
  input  wire logic               in_ir_front_left,
  input  wire logic               in_ir_front_middle,
  input  wire logic               in_ir_front_right,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [MOT_W-1:0]   out_motion,
  output logic      [SPEED_W-1:0] out_speed,
  output logic                    out_docked,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  logic [DIST_W-1:0]  stop_dist_r;
  logic [SPEED_W-1:0] drive_spd_r;
  logic               cfg_wr;

  logic               in_valid_r;
  logic [DIST_W-1:0]  dist_r;
  ir_flags_t          flags_r;
  logic               move;

  logic               stopped;
  logic [MOT_W-1:0]   motion;
  logic [SPEED_W-1:0] speed_nxt;

  logic               out_valid_r;
  logic [MOT_W-1:0]   motion_r;
  logic [SPEED_W-1:0] speed_r;
  logic               docked_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_dist_r <= STOP_DIST_RST;
      drive_spd_r <= DRIVE_SPD_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STOP_DIST: stop_dist_r <= pwdata[DIST_W-1:0];
        REG_DRIVE_SPD: drive_spd_r <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STOP_DIST: prdata = DATA_W'(stop_dist_r);
      REG_DRIVE_SPD: prdata = DATA_W'(drive_spd_r);
      default:       prdata = '0;
    endcase
  end

  assign move     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dist_r   <= in_distance;
      flags_r  <= '{l: in_ir_left, r: in_ir_right, fl: in_ir_front_left,
                    fm: in_ir_front_middle, fr: in_ir_front_right};
    end
  end

  dsc_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (move),
    .range_in      (dist_r),
    .stop_distance (stop_dist_r),
    .stopped       (stopped)
  );

  dsc_steer u_steer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (move),
    .stopped (stopped),
    .flags   (flags_r),
    .motion  (motion)
  );

  assign speed_nxt = (motion == MOT_STOP || motion == MOT_NONE) ? '0 : drive_spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      motion_r <= motion;
      speed_r  <= speed_nxt;
      docked_r <= stopped;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_motion = motion_r;
  assign out_speed  = speed_r;
  assign out_docked = docked_r;

  a_docked_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_docked == (out_motion == MOT_STOP)))
    else $error("docked flag disagrees with stop command");

  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion == MOT_STOP || out_motion == MOT_NONE) |-> out_speed == '0)
    else $error("nonzero speed on stop or idle command");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid)
    else $error("evaluated beat did not reach result register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |=> in_valid_r && out_valid_r)
    else $error("pending beat lost while receiver stalled");

endmodule
`default_nettype wire

>>> hw/rtl/dsc_window.sv
`default_nettype none
module dsc_window import dsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [DIST_W-1:0] range_in,
  input  wire logic [DIST_W-1:0] stop_distance,
  output logic                   stopped
);

  logic [DIST_W-1:0] sample_r [WIN_LEN];
  logic [DIST_W-1:0] held_r   [WIN_LEN];
  logic [DIST_W-1:0] sample_nxt [WIN_LEN];
  logic [DIST_W-1:0] held_nxt   [WIN_LEN];
  logic [SLOT_W-1:0] slot_r, slot_nxt, slot_cur;
  logic              sampling_r;
  logic              wrap;

  always_comb begin
    slot_cur = (32'(slot_r) >= WIN_LEN) ? SLOT_TOP : slot_r;
    wrap     = sampling_r && (slot_cur == '0);
    slot_nxt = slot_r;
    if (sampling_r) begin
      slot_nxt = wrap ? SLOT_TOP : slot_cur - SLOT_W'(1);
    end
    stopped = 1'b1;
    for (int k = 0; k < WIN_LEN; k++) begin
      sample_nxt[k] = (sampling_r && slot_cur == SLOT_W'(k)) ? range_in : sample_r[k];
      held_nxt[k]   = wrap ? sample_nxt[k] : held_r[k];
      if (!(held_nxt[k] < stop_distance)) begin
        stopped = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        sample_r[k] <= WINDOW_RESET;
        held_r[k]   <= WINDOW_RESET;
      end
      slot_r     <= SLOT_TOP;
      sampling_r <= 1'b1;
    end else if (advance) begin
      sample_r   <= sample_nxt;
      held_r     <= held_nxt;
      slot_r     <= slot_nxt;
      sampling_r <= !stopped;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dsc_steer.sv
`default_nettype none
module dsc_steer import dsc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             stopped,
  input  wire ir_flags_t        flags,
  output logic      [MOT_W-1:0] motion
);

  logic right_armed_r, left_armed_r, turn_r_r, turn_l_r;
  logic right_armed_nxt, left_armed_nxt, turn_r_nxt, turn_l_nxt;
  logic all_front;

  always_comb begin
    all_front       = flags.fl && flags.fm && flags.fr;
    right_armed_nxt = right_armed_r;
    left_armed_nxt  = left_armed_r;
    turn_r_nxt      = turn_r_r;
    turn_l_nxt      = turn_l_r;
    motion          = MOT_NONE;
    if (stopped) begin
      motion = MOT_STOP;
    end else begin
      turn_r_nxt = turn_r_r || (flags.r && right_armed_r);
      turn_l_nxt = turn_l_r || (flags.l && left_armed_r);
      if (turn_r_nxt || turn_l_nxt) begin
        if (turn_r_nxt && turn_l_nxt) begin
          if (flags.r) begin
            turn_l_nxt = 1'b0;
          end else begin
            turn_r_nxt = 1'b0;
          end
        end
        motion = turn_r_nxt ? MOT_RIGHT : MOT_LEFT;
        if (all_front) begin
          turn_r_nxt      = 1'b0;
          turn_l_nxt      = 1'b0;
          right_armed_nxt = 1'b0;
          left_armed_nxt  = 1'b0;
          motion          = MOT_BACK;
        end
      end else if (!right_armed_r && !left_armed_r) begin
        if (flags.fm) begin
          if (flags.fl == flags.fr) begin
            motion = MOT_BACK;
          end else if (flags.fr) begin
            motion = MOT_RIGHT;
          end else begin
            motion = MOT_LEFT;
          end
        end
      end else begin
        motion = MOT_FWD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_armed_r <= 1'b1;
      left_armed_r  <= 1'b1;
      turn_r_r      <= 1'b0;
      turn_l_r      <= 1'b0;
    end else if (advance) begin
      right_armed_r <= right_armed_nxt;
      left_armed_r  <= left_armed_nxt;
      turn_r_r      <= turn_r_nxt;
      turn_l_r      <= turn_l_nxt;
    end
  end

endmodule
`default_nettype wire

>>> test/ir_docking_steer_controller_core_tb.sv
`timescale 1ns / 1ps
module ir_docking_steer_controller_core_tb;
  import dsc_pkg::*;

  typedef struct packed {
    logic [MOT_W-1:0]   motion;
    logic [SPEED_W-1:0] speed;
    logic               docked;
  } steer_cmd_t;

  class steer_tracker;
    logic [DIST_W-1:0]  stop_dist;
    logic [SPEED_W-1:0] drive_spd;
    logic [DIST_W-1:0]  samples[WIN_LEN];
    logic [DIST_W-1:0]  held[WIN_LEN];
    int                 slot;
    bit                 sampling;
    bit                 right_armed;
    bit                 left_armed;
    bit                 turn_right;
    bit                 turn_left;
    steer_cmd_t         pending_cmds[$];
    int                 errors;

    function new();
      stop_dist   = STOP_DIST_RST;
      drive_spd   = DRIVE_SPD_RST;
      foreach (samples[k]) begin
        samples[k] = WINDOW_RESET;
        held[k]    = WINDOW_RESET;
      end
      slot        = int'(SLOT_TOP);
      sampling    = 1;
      right_armed = 1;
      left_armed  = 1;
      turn_right  = 0;
      turn_left   = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] v);
      if (idx == REG_STOP_DIST) begin
        stop_dist = v[DIST_W-1:0];
      end else begin
        drive_spd = v[SPEED_W-1:0];
      end
    endfunction

    function void take_tick(logic [DIST_W-1:0] range_in, ir_flags_t f);
      steer_cmd_t       cmd;
      logic             halt;
      logic [MOT_W-1:0] mot;
      if (sampling) begin
        samples[slot] = range_in;
        if (slot == 0) begin
          slot = WIN_LEN - 1;
          held = samples;
        end else begin
          slot--;
        end
      end
      halt = 1;
      foreach (held[k]) begin
        if (held[k] >= stop_dist) halt = 0;
      end
      sampling = !halt;
      mot = MOT_NONE;
      if (halt) begin
        mot = MOT_STOP;
      end else begin
        if (f.r && right_armed) turn_right = 1;
        if (f.l && left_armed) turn_left = 1;
        if (turn_right || turn_left) begin
          if (turn_right && turn_left) begin
            if (f.r) turn_left = 0;
            else turn_right = 0;
          end
          mot = turn_right ? MOT_RIGHT : MOT_LEFT;
          if (f.fl && f.fm && f.fr) begin
            turn_right  = 0;
            turn_left   = 0;
            right_armed = 0;
            left_armed  = 0;
            mot         = MOT_BACK;
          end
        end else if (!right_armed && !left_armed) begin
          if (f.fm) begin
            if (f.fl == f.fr) mot = MOT_BACK;
            else if (f.fr) mot = MOT_RIGHT;
            else mot = MOT_LEFT;
          end
        end else begin
          mot = MOT_FWD;
        end
      end
      cmd.motion = mot;
      cmd.speed  = (mot == MOT_STOP || mot == MOT_NONE) ? '0 : drive_spd;
      cmd.docked = halt;
      pending_cmds.push_back(cmd);
    endfunction

    function void match_cmd(logic [MOT_W-1:0] m, logic [SPEED_W-1:0] s, logic d);
      steer_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result beat motion %0d speed %0d docked %0b",
                 $time, m, s, d);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (m !== want.motion) begin
          $display("%0t: motion expected %0d actual %0d", $time, want.motion, m);
          errors++;
        end
        if (s !== want.speed) begin
          $display("%0t: speed expected %0d actual %0d", $time, want.speed, s);
          errors++;
        end
        if (d !== want.docked) begin
          $display("%0t: docked expected %0b actual %0b", $time, want.docked, d);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [DIST_W-1:0]  in_distance = '0;
  logic               in_ir_left = 1'b0;
  logic               in_ir_right = 1'b0;
  logic               in_ir_front_left = 1'b0;
  logic               in_ir_front_middle = 1'b0;
  logic               in_ir_front_right = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [MOT_W-1:0]   out_motion;
  logic [SPEED_W-1:0] out_speed;
  logic               out_docked;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  steer_tracker tracker;
  bit           quiet = 0;

  ir_docking_steer_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_distance        (in_distance),
    .in_ir_left         (in_ir_left),
    .in_ir_right        (in_ir_right),
    .in_ir_front_left   (in_ir_front_left),
    .in_ir_front_middle (in_ir_front_middle),
    .in_ir_front_right  (in_ir_front_right),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_motion         (out_motion),
    .out_speed          (out_speed),
    .out_docked         (out_docked),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.match_cmd(out_motion, out_speed, out_docked);
      if (in_valid && in_ready) begin
        tracker.take_tick(in_distance, '{l: in_ir_left, r: in_ir_right,
                                         fl: in_ir_front_left, fm: in_ir_front_middle,
                                         fr: in_ir_front_right});
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_tick(input logic [DIST_W-1:0] d, input ir_flags_t f);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_distance        <= d;
    in_ir_left         <= f.l;
    in_ir_right        <= f.r;
    in_ir_front_left   <= f.fl;
    in_ir_front_middle <= f.fm;
    in_ir_front_right  <= f.fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    logic [DIST_W-1:0] dists[17] = '{1023, 0, 512, 300, 5, 900, 200, 1, 700,
                                     64, 3, 1000, 0, 6, 3, 1023, 0};
    logic [4:0]        flags[17] = '{5'b00000, 5'b00111, 5'b10000, 5'b01000,
                                     5'b10000, 5'b00110, 5'b00111, 5'b00111,
                                     5'b00010, 5'b00011, 5'b00110, 5'b00101,
                                     5'b11000, 5'b00000, 5'b00010, 5'b11111,
                                     5'b00000};
    foreach (dists[k]) send_tick(dists[k], ir_flags_t'(flags[k]));
  endtask

  task automatic run_phase(input int thr);
    bit                halt_run;
    logic [DIST_W-1:0] d;
    halt_run = 1'($urandom_range(0, 1));
    for (int k = 0; k < 133; k++) begin
      if (k >= 115 && halt_run && thr > 0) d = DIST_W'($urandom_range(0, thr - 1));
      else if ($urandom_range(0, 3) == 0) d = DIST_W'($urandom_range(0, 15));
      else d = DIST_W'($urandom_range(0, 1023));
      send_tick(d, ir_flags_t'(5'($urandom_range(0, 31))));
    end
  endtask

  initial begin
    int          stop_pick[5] = '{0, 1023, 7, 1, 512};
    int          speed_pick[5] = '{0, 4095, 1000, 1, 2048};
    int          thr;
    logic [31:0] v;
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph == 9) quiet = 1;
      thr = (ph < 5) ? stop_pick[ph] : int'($urandom_range(0, 1023));
      v = $urandom();
      v[DIST_W-1:0] = DIST_W'(thr);
      apb_write(REG_STOP_DIST, v);
      v = $urandom();
      v[SPEED_W-1:0] = (ph < 5) ? SPEED_W'(speed_pick[ph])
                                : SPEED_W'($urandom_range(0, 4095));
      apb_write(REG_DRIVE_SPD, v);
      run_phase(thr);
    end
    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_cmds.size() == 0) begin
      $display("ir_docking_steer_controller_core test passed");
    end else begin
      $display("ir_docking_steer_controller_core test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ir_docking_steer_controller_core test failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_window.sv
hw/rtl/dsc_steer.sv
hw/rtl/ir_docking_steer_controller_core.sv
test/ir_docking_steer_controller_core_tb.sv
